[hdl/dgs_pkg.sv]
`default_nettype none
package dgs_pkg;

	localparam int MaxWidth  = 2048;
	localparam int MaxHeight = 2048;

	localparam int ColW = $clog2(MaxWidth);
	localparam int RowW = $clog2(MaxHeight);
	localparam int PixW = 8;
	localparam int CfgW = 12;
	localparam int IdxW = 2;

	localparam int ResetWidth  = 640;
	localparam int ResetHeight = 480;

	typedef enum logic [IdxW-1:0] {
		REG_DIRECTION = 2'd0,
		REG_WIDTH     = 2'd1,
		REG_HEIGHT    = 2'd2
	} cfg_reg_t;

	// one pipeline word
	typedef struct packed {
		logic [PixW-1:0] pixel;
		logic [PixW-1:0] nbr;
		logic            from_store;
		logic            zero;
		logic            last;
	} word_t;

	// scan position of the pixel now at the input
	typedef struct packed {
		logic first_col;
		logic first_row;
		logic last;
	} pos_t;

	// last index of a dimension: 0 reads as 1, anything above the maximum as the maximum
	function automatic logic [CfgW:0] clamp_last(input logic [CfgW-1:0] v, input int maxv);
		logic [CfgW:0] r;
		if (v == '0) begin
			r = '0;
		end else if (int'(v) > maxv) begin
			r = (CfgW+1)'(maxv - 1);
		end else begin
			r = {1'b0, v} - (CfgW+1)'(1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/directional_gradient_stream.sv]
`default_nettype none
// Absolute first-difference gradient over 8-bit grayscale pixels in raster
// order: one gradient word out for every pixel word in, one pixel per clock
// sustained; the pixel and then its gradient are registered. The rate is
// set by the line store, a MaxWidth x 8 memory read and written at the column
// of the pixel in the cycle the pixel is taken, and by the two-cell pipeline
// (scan cell, result cell) that carries the word on; each cell refills as
// it empties, so the input only stalls when the output is stalled with
// both cells full. direction_mode picks left neighbour (0) or pixel above
// (1); the first column or first row gives 0. Writing line_width or
// frame_height restarts the frame; direction_mode applies from the next
// pixel. Register writes belong to idle periods only. Line store entries
// are always written one row before they are read, so no clearing is done.
module directional_gradient_stream
	import dgs_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_wr_en,
	input  wire logic [IdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0] cfg_data,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [PixW-1:0] pixel_value,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [PixW-1:0]      gradient_value,
	output logic                 frame_last
);

	logic            accept;
	word_t           scan_word;
	logic [PixW-1:0] store_q;
	pos_t            pos;

	logic            s1_valid;
	logic            s1_stall;
	word_t           s1_word;
	word_t           s2_in;
	word_t           s2_word;
	logic [PixW-1:0] nbr_s1;

	assign accept = in_valid & ~in_stall;

	// counters, left pixel and line store
	dgs_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.pixel     (pixel_value),
		.word      (scan_word),
		.store_q   (store_q),
		.pos       (pos)
	);

	// first cell: pixel and its neighbour; the pixel above lands in store_q
	// alongside, and holds as long as this cell holds
	dgs_cell u_cell_s1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (scan_word),
		.out_valid (s1_valid),
		.out_stall (s1_stall),
		.out_word  (s1_word)
	);

	// gradient between the cells
	always_comb begin
		nbr_s1 = s1_word.from_store ? store_q : s1_word.nbr;
		s2_in  = s1_word;
		if (s1_word.zero) begin
			s2_in.pixel = '0;
		end else if (s1_word.pixel >= nbr_s1) begin
			s2_in.pixel = s1_word.pixel - nbr_s1;
		end else begin
			s2_in.pixel = nbr_s1 - s1_word.pixel;
		end
		s2_in.nbr = nbr_s1;
	end

	// second cell: output register
	dgs_cell u_cell_s2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s1_valid),
		.in_stall  (s1_stall),
		.in_word   (s2_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (s2_word)
	);

	assign gradient_value = s2_word.pixel;
	assign frame_last     = s2_word.last;

	// input only backs up when the output register is full
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output register");

	// the last pixel of a frame wraps the scan to the origin
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos.last && !cfg_wr_en) |=> (pos.first_col && pos.first_row))
		else $error("scan did not wrap after last pixel");

	// a geometry write restarts the frame
	a_geom_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT))
		|=> (pos.first_col && pos.first_row))
		else $error("geometry write did not restart frame");

endmodule
`default_nettype wire

[hdl/dgs_cell.sv]
`default_nettype none
module dgs_cell
	import dgs_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire word_t in_word,
	output logic       out_valid,
	input  wire logic  out_stall,
	output word_t      out_word
);

	logic  valid_q;
	word_t word_q;

	// refill in the same cycle the held word leaves
	assign in_stall  = valid_q & out_stall;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_q <= in_word;
		end
	end

endmodule
`default_nettype wire

[hdl/dgs_scan.sv]
`default_nettype none
module dgs_scan
	import dgs_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_wr_en,
	input  wire logic [IdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0] cfg_data,
	input  wire logic            accept,
	input  wire logic [PixW-1:0] pixel,
	output word_t                word,
	output logic [PixW-1:0]      store_q,
	output pos_t                 pos
);

	logic            mode_q;
	logic [ColW-1:0] last_col_q;
	logic [RowW-1:0] last_row_q;
	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;
	logic [PixW-1:0] left_q;
	logic [PixW-1:0] mem [MaxWidth];
	logic [CfgW:0]   w_last;
	logic [CfgW:0]   h_last;

	assign w_last = clamp_last(cfg_data, MaxWidth);
	assign h_last = clamp_last(cfg_data, MaxHeight);

	always_comb begin
		pos.first_col = (col_q == '0);
		pos.first_row = (row_q == '0);
		pos.last      = (col_q == last_col_q) && (row_q == last_row_q);

		word.pixel      = pixel;
		word.nbr        = left_q;
		word.from_store = mode_q;
		word.zero       = mode_q ? pos.first_row : pos.first_col;
		word.last       = pos.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			last_col_q <= ColW'(ResetWidth - 1);
			last_row_q <= RowW'(ResetHeight - 1);
			col_q      <= '0;
			row_q      <= '0;
			left_q     <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DIRECTION: begin
					mode_q <= cfg_data[0];
				end
				REG_WIDTH: begin
					last_col_q <= w_last[ColW-1:0];
					col_q      <= '0;
					row_q      <= '0;
					left_q     <= '0;
				end
				REG_HEIGHT: begin
					last_row_q <= h_last[RowW-1:0];
					col_q      <= '0;
					row_q      <= '0;
					left_q     <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			left_q <= pixel;
			if (col_q == last_col_q) begin
				col_q <= '0;
				row_q <= (row_q == last_row_q) ? '0 : row_q + RowW'(1);
			end else begin
				col_q <= col_q + ColW'(1);
			end
		end
	end

	// read-first: the pixel above comes out as this column is overwritten
	always_ff @(posedge clk) begin
		if (accept) begin
			store_q    <= mem[col_q];
			mem[col_q] <= pixel;
		end
	end

endmodule
`default_nettype wire

[test/directional_gradient_stream_tb.sv]
`timescale 1ns / 1ps

module directional_gradient_stream_tb;
	import dgs_pkg::*;

	localparam int RandomItems = 550;
	localparam int IdleLimit   = 2000;	// cycles with no word moving on either side
	localparam int LongHold    = 64;	// receiver hold-off for the back-pressure phase
	localparam int PressPhase  = 5;
	localparam int ReportMax   = 10;
	localparam int TailCycles  = 8;	// two-cell pipeline, with margin

	// register index past the end of the map; the block must ignore it
	localparam logic [IdxW-1:0] REG_NONE = 2'd3;
	localparam logic [CfgW-1:0] DIR_HORIZONTAL = 12'd0;
	localparam logic [CfgW-1:0] DIR_VERTICAL   = 12'd1;

	typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

	// one gradient word as it leaves the block
	typedef struct packed {
		logic [PixW-1:0] grad;
		logic            last;
	} grad_word_t;

	// one row of the directed script
	typedef struct packed {
		step_kind_t      kind;
		logic [IdxW-1:0] idx;
		logic [CfgW-1:0] data;
		logic [PixW-1:0] pix;
		logic            known;	// result typed in below rather than predicted
		grad_word_t      want;
	} step_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_wr_en;
	logic [IdxW-1:0] cfg_index;
	logic [CfgW-1:0] cfg_data;
	logic            in_valid;
	logic            in_stall;
	logic [PixW-1:0] pixel_value;
	logic            out_valid;
	logic            out_stall;
	logic [PixW-1:0] gradient_value;
	logic            frame_last;

	directional_gradient_stream dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel_value    (pixel_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.gradient_value (gradient_value),
		.frame_last     (frame_last)
	);

	// ---------------------------------------------------------------------
	// Gradient predictor: own copy of the scan state and the registers.
	// ---------------------------------------------------------------------
	logic [PixW-1:0] line_mem [MaxWidth];	// previous row, by column
	logic [PixW-1:0] prev_pixel;
	int unsigned     scan_col;
	int unsigned     scan_row;
	logic            dir_vertical;
	logic [CfgW-1:0] width_reg;
	logic [CfgW-1:0] height_reg;

	grad_word_t gradient_due [$];	// predicted words not yet seen at the output
	int         mismatch_count;
	bit         offering;	// in_valid is (or is about to be) high
	bit         steady;	// no random idling on either side this phase
	bit         hold_request;	// ask the receiver for one long hold-off

	// geometry as the block uses it: zero reads as one, anything past the top as the top
	function automatic int unsigned usable_dim(logic [CfgW-1:0] v, int unsigned top);
		if (v == '0)
			return 1;
		if (int'(v) > top)
			return top;
		return v;
	endfunction

	// gradient and end-of-frame flag for one pixel; advances the scan state
	function automatic grad_word_t predict_gradient(logic [PixW-1:0] pix);
		int unsigned     w;
		int unsigned     h;
		int unsigned     c;
		int unsigned     r;
		logic [PixW-1:0] nbr;
		grad_word_t      res;
		w = usable_dim(width_reg, MaxWidth);
		h = usable_dim(height_reg, MaxHeight);
		c = (scan_col >= w) ? 0 : scan_col;
		r = (scan_row >= h) ? 0 : scan_row;
		res.grad = '0;
		// first column (horizontal) or first row (vertical) gives zero
		if (dir_vertical ? (r != 0) : (c != 0)) begin
			nbr = dir_vertical ? line_mem[c] : prev_pixel;
			res.grad = (pix >= nbr) ? pix - nbr : nbr - pix;
		end
		res.last = (c == w - 1) && (r == h - 1);
		// the store and the left neighbour are written in both modes
		line_mem[c] = pix;
		prev_pixel = pix;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		scan_col = c;
		scan_row = r;
		return res;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [PixW-1:0] random_pixel();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return PixW'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic step_t reg_row(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
		step_t s;
		s = '0;
		s.kind = STEP_WRITE;
		s.idx = idx;
		s.data = data;
		return s;
	endfunction

	function automatic step_t pix_row(logic [PixW-1:0] pix);
		step_t s;
		s = '0;
		s.kind = STEP_PIXEL;
		s.pix = pix;
		return s;
	endfunction

	function automatic step_t pix_row_known(logic [PixW-1:0] pix, logic [PixW-1:0] grad,
			logic last);
		step_t s;
		s = pix_row(pix);
		s.known = 1'b1;
		s.want.grad = grad;
		s.want.last = last;
		return s;
	endfunction

	task automatic report_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= ReportMax)
			$display("[%0t] %s", $time, msg);
	endtask

	// Offer one pixel word after a random gap and hold it until taken.
	// Called on a rising edge; returns on the edge that accepted the word.
	task automatic push_pixel(input logic [PixW-1:0] pix, input logic known,
			input grad_word_t want);
		int unsigned gap;
		grad_word_t  pred;
		gap = idle_len();
		if (gap > 0) begin
			if (offering)
				in_valid <= 1'b0;
			offering = 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_value <= pix;
		offering = 1;
		do
			@(posedge clk);
		while (in_stall);
		pred = predict_gradient(pix);
		gradient_due.push_back(known ? want : pred);
	endtask

	// stop offering and wait for every predicted word to come out
	task automatic drain_results();
		if (offering)
			in_valid <= 1'b0;
		offering = 0;
		while (gradient_due.size() != 0)
			@(posedge clk);
	endtask

	// one register write, block idle; the predictor follows at the write edge
	task automatic apply_write(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_DIRECTION: dir_vertical = data[0];
			REG_WIDTH, REG_HEIGHT: begin
				if (idx == REG_WIDTH)
					width_reg = data;
				else
					height_reg = data;
				// geometry write restarts the frame
				scan_col = 0;
				scan_row = 0;
				prev_pixel = '0;
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Clock
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off on request so the
	// two cells fill and the block has to stall its input.
	// ---------------------------------------------------------------------
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 0;
				stall_left = LongHold;
			end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
				stall_left = idle_len();
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Output check: every word taken is matched against the oldest
	// prediction, both fields.
	// ---------------------------------------------------------------------
	initial begin
		grad_word_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
				if (gradient_due.size() == 0) begin
					report_error($sformatf("unexpected word: grad %0h last %0b",
						gradient_value, frame_last));
				end else begin
					want = gradient_due.pop_front();
					if (gradient_value !== want.grad || frame_last !== want.last)
						report_error($sformatf(
							"mismatch: grad exp %0h got %0h, last exp %0b got %0b",
							want.grad, gradient_value, want.last, frame_last));
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Watchdog: too long with no word moving means a hang.
	// ---------------------------------------------------------------------
	initial begin
		int unsigned idle;
		idle = 0;
		while (idle < IdleLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	initial begin
		step_t           script [$];
		int unsigned     random_sent;
		int unsigned     phase;
		int unsigned     burst;
		int unsigned     split;
		int unsigned     frame_len;
		int unsigned     which;
		logic [CfgW-1:0] new_w;
		logic [CfgW-1:0] new_h;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_DIRECTION;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_value = '0;
		mismatch_count = 0;
		offering = 0;
		steady = 0;
		hold_request = 0;

		// reset state of the predictor
		foreach (line_mem[i])
			line_mem[i] = '0;
		prev_pixel = '0;
		scan_col = 0;
		scan_row = 0;
		dir_vertical = 1'b0;
		width_reg = CfgW'(ResetWidth);
		height_reg = CfgW'(ResetHeight);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Starts from the reset geometry, horizontal mode.
		script.push_back(pix_row_known(8'h00, 8'h00, 1'b0));	// first column
		script.push_back(pix_row_known(8'hFF, 8'hFF, 1'b0));	// full swing up
		script.push_back(pix_row_known(8'h00, 8'hFF, 1'b0));	// and down
		script.push_back(pix_row(8'hA5));
		// zero geometry reads as one pixel per frame
		script.push_back(reg_row(REG_WIDTH, 12'd0));
		script.push_back(reg_row(REG_HEIGHT, 12'd0));
		script.push_back(pix_row_known(8'h5A, 8'h00, 1'b1));
		// only bit 0 of the direction word counts
		script.push_back(reg_row(REG_DIRECTION, 12'hFFF));
		script.push_back(pix_row_known(8'hFF, 8'h00, 1'b1));
		// single-column frame, three rows, vertical
		script.push_back(reg_row(REG_HEIGHT, 12'd3));
		script.push_back(pix_row_known(8'h10, 8'h00, 1'b0));
		script.push_back(pix_row_known(8'hF0, 8'hE0, 1'b0));
		script.push_back(pix_row_known(8'h00, 8'hF0, 1'b1));
		script.push_back(pix_row_known(8'h33, 8'h00, 1'b0));
		// geometry past the top clamps to the maximum
		script.push_back(reg_row(REG_WIDTH, 12'hFFF));
		script.push_back(reg_row(REG_HEIGHT, 12'hFFF));
		script.push_back(pix_row_known(8'h7F, 8'h00, 1'b0));
		script.push_back(pix_row_known(8'h80, 8'h00, 1'b0));
		// direction change keeps the scan position; upper bits ignored
		script.push_back(reg_row(REG_DIRECTION, 12'h002));
		script.push_back(pix_row_known(8'h00, 8'h80, 1'b0));
		// write to an index past the map does nothing
		script.push_back(reg_row(REG_NONE, 12'hFFF));
		script.push_back(pix_row_known(8'hFF, 8'hFF, 1'b0));
		// 2x2: top row in horizontal mode, read back from the store in vertical
		script.push_back(reg_row(REG_WIDTH, 12'd2));
		script.push_back(reg_row(REG_HEIGHT, 12'd2));
		script.push_back(pix_row_known(8'h01, 8'h00, 1'b0));
		script.push_back(pix_row_known(8'h03, 8'h02, 1'b0));
		script.push_back(reg_row(REG_DIRECTION, DIR_VERTICAL));
		script.push_back(pix_row_known(8'h80, 8'h7F, 1'b0));
		script.push_back(pix_row_known(8'h7F, 8'h7C, 1'b1));
		script.push_back(reg_row(REG_DIRECTION, DIR_HORIZONTAL));
		script.push_back(pix_row_known(8'h00, 8'h00, 1'b0));
		script.push_back(pix_row_known(8'hFF, 8'hFF, 1'b0));
		script.push_back(reg_row(REG_DIRECTION, DIR_VERTICAL));
		script.push_back(pix_row_known(8'h01, 8'h01, 1'b0));
		script.push_back(pix_row_known(8'hFE, 8'h01, 1'b1));
		// exact maximum width, single row
		script.push_back(reg_row(REG_WIDTH, 12'd2048));
		script.push_back(reg_row(REG_HEIGHT, 12'd1));
		script.push_back(pix_row(8'hC3));
		script.push_back(pix_row(8'h3C));

		foreach (script[i]) begin
			if (script[i].kind == STEP_WRITE) begin
				drain_results();
				apply_write(script[i].idx, script[i].data);
			end else begin
				push_pixel(script[i].pix, script[i].known, script[i].want);
			end
		end

		// Random part: one phase per geometry. Bursts cover whole frames
		// where frames are small, so vertical mode gets past the first row;
		// the first phases take the geometry extremes with short bursts.
		random_sent = 0;
		phase = 0;
		while (random_sent < RandomItems) begin
			drain_results();
			steady = ($urandom_range(0, 3) == 0);
			case (phase)
				0: begin new_w = 12'd0;    new_h = 12'd2;    end
				1: begin new_w = 12'hFFF;  new_h = 12'd2;    end
				2: begin new_w = 12'd1;    new_h = 12'hFFF;  end
				3: begin new_w = 12'd2048; new_h = 12'd0;    end
				default: begin
					new_w = ($urandom_range(0, 9) == 0) ? CfgW'($urandom_range(13, 40))
						: CfgW'($urandom_range(1, 12));
					new_h = CfgW'($urandom_range(1, 6));
				end
			endcase
			which = (phase < 4) ? 2 : $urandom_range(0, 2);
			if (which != 1)
				apply_write(REG_WIDTH, new_w);
			if (which != 0)
				apply_write(REG_HEIGHT, new_h);
			if ($urandom_range(0, 1) == 0)
				apply_write(REG_DIRECTION, CfgW'($urandom_range(0, 4095)));
			if ($urandom_range(0, 9) == 0)
				apply_write(REG_NONE, CfgW'($urandom_range(0, 4095)));

			frame_len = usable_dim(width_reg, MaxWidth) * usable_dim(height_reg, MaxHeight);
			burst = (frame_len > 32) ? 24 + $urandom_range(0, 16)
				: 2 * frame_len + $urandom_range(0, 4);
			split = $urandom_range(0, burst);
			if (phase == PressPhase) begin
				// back-to-back words into a receiver that holds off for a long stretch
				steady = 1;
				hold_request = 1;
				burst = 24;
				split = 0;
			end

			for (int unsigned i = 0; i < burst; i++) begin
				// direction write mid-frame: scan position carries on
				if (i == split && i != 0) begin
					drain_results();
					apply_write(REG_DIRECTION, CfgW'($urandom_range(0, 4095)));
				end
				push_pixel(random_pixel(), 1'b0, '0);
				random_sent++;
			end
			phase++;
		end

		drain_results();
		repeat (TailCycles) @(posedge clk);

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
hdl/dgs_pkg.sv
hdl/dgs_cell.sv
hdl/dgs_scan.sv
hdl/directional_gradient_stream.sv
test/directional_gradient_stream_tb.sv
